// ===== sv/bbp_pkg.sv =====
package bbp_pkg;

  localparam int VAL_W         = 48;
  localparam int WGT_W         = 32;
  localparam int STEPS_W       = 7;
  localparam int MASK_W        = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int DEF_MAX_STEPS = 64;
  localparam int QSHIFT        = 30;

  localparam logic [WGT_W-1:0]   RST_FACTOR = WGT_W'(32'h4000_0000);
  localparam logic [STEPS_W-1:0] RST_STEPS  = STEPS_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_PROB_DISC   = 3'd0,
    REG_DOWN_PROB_DISC = 3'd1,
    REG_DOWN_FACTOR    = 3'd2,
    REG_UP_SQUARED     = 3'd3,
    REG_LOWEST_FACTOR  = 3'd4,
    REG_STEPS_IN_USE   = 3'd5,
    REG_EXERCISE_MASK  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_MUL,
    S_UPD,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_MUL,
    CELL_UPD
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             ex;
    logic [VAL_W-1:0] strike;
  } cell_ctl_t;

  typedef struct packed {
    logic [WGT_W-1:0] up_prob_disc;
    logic [WGT_W-1:0] down_prob_disc;
    logic [WGT_W-1:0] down_factor;
  } wgt_t;

  // (a * f) >> 30, saturated to 48 bits; the 48x32 product is built from two 24x32 halves
  function automatic logic [VAL_W-1:0] qmul(input logic [VAL_W-1:0] a,
                                           input logic [WGT_W-1:0] f);
    logic [VAL_W/2+WGT_W-1:0] hi;
    logic [VAL_W/2+WGT_W-1:0] lo;
    logic [VAL_W+WGT_W-1:0]   full;
    logic [VAL_W+WGT_W-QSHIFT-1:0] r;
    hi   = a[VAL_W-1:VAL_W/2] * f;
    lo   = a[VAL_W/2-1:0] * f;
    full = {hi, (VAL_W/2)'(0)} + (VAL_W+WGT_W)'(lo);
    r    = full[VAL_W+WGT_W-1:QSHIFT];
    if (|r[VAL_W+WGT_W-QSHIFT-1:VAL_W]) begin
      qmul = '1;
    end else begin
      qmul = r[VAL_W-1:0];
    end
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[VAL_W]) begin
      sat_add = '1;
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

  function automatic logic [VAL_W-1:0] payoff(input logic [VAL_W-1:0] strike,
                                             input logic [VAL_W-1:0] price);
    if (strike > price) begin
      payoff = strike - price;
    end else begin
      payoff = '0;
    end
  endfunction

endpackage

// ===== sv/bbp_gen.sv =====
module bbp_gen (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step_en,
  input  logic [bbp_pkg::VAL_W-1:0]     spot,
  input  logic [bbp_pkg::VAL_W-1:0]     strike,
  input  logic [bbp_pkg::WGT_W-1:0]     lowest_price_factor,
  input  logic [bbp_pkg::WGT_W-1:0]     up_squared,
  output logic [bbp_pkg::VAL_W-1:0]     price,
  output logic [bbp_pkg::VAL_W-1:0]     value
);

  logic [bbp_pkg::VAL_W-1:0] price_r;
  logic [bbp_pkg::VAL_W-1:0] price_nxt;

  // terminal prices come out lowest first, one per cycle while step_en is high
  always_comb begin
    price_nxt = price_r;
    if (load) begin
      price_nxt = bbp_pkg::qmul(spot, lowest_price_factor);
    end else if (step_en) begin
      price_nxt = bbp_pkg::qmul(price_r, up_squared);
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
  end

  assign price = price_r;
  assign value = bbp_pkg::payoff(strike, price_r);

endmodule

// ===== sv/bbp_cell.sv =====
module bbp_cell (
  input  logic                      clk,
  input  bbp_pkg::cell_ctl_t        ctl,
  input  bbp_pkg::wgt_t             wgt,
  input  logic [bbp_pkg::VAL_W-1:0] shift_price,
  input  logic [bbp_pkg::VAL_W-1:0] shift_value,
  input  logic [bbp_pkg::VAL_W-1:0] lo_value,
  output logic [bbp_pkg::VAL_W-1:0] price,
  output logic [bbp_pkg::VAL_W-1:0] value
);

  logic [bbp_pkg::VAL_W-1:0] price_r, price_nxt;
  logic [bbp_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [bbp_pkg::VAL_W-1:0] vup_r, vup_nxt;
  logic [bbp_pkg::VAL_W-1:0] vdn_r, vdn_nxt;
  logic [bbp_pkg::VAL_W-1:0] pnx_r, pnx_nxt;
  logic [bbp_pkg::VAL_W-1:0] cont;
  logic [bbp_pkg::VAL_W-1:0] exv;

  assign cont = bbp_pkg::sat_add(vup_r, vdn_r);
  assign exv  = bbp_pkg::payoff(ctl.strike, pnx_r);

  // this cell is the upper child, the lower neighbor the lower child
  always_comb begin
    price_nxt = price_r;
    value_nxt = value_r;
    vup_nxt   = vup_r;
    vdn_nxt   = vdn_r;
    pnx_nxt   = pnx_r;
    unique case (ctl.op)
      bbp_pkg::CELL_HOLD: begin
      end
      bbp_pkg::CELL_SHIFT: begin
        price_nxt = shift_price;
        value_nxt = shift_value;
      end
      bbp_pkg::CELL_MUL: begin
        vup_nxt = bbp_pkg::qmul(value_r, wgt.up_prob_disc);
        vdn_nxt = bbp_pkg::qmul(lo_value, wgt.down_prob_disc);
        pnx_nxt = bbp_pkg::qmul(price_r, wgt.down_factor);
      end
      bbp_pkg::CELL_UPD: begin
        price_nxt = pnx_r;
        value_nxt = (ctl.ex && (exv > cont)) ? exv : cont;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    value_r <= value_nxt;
    vup_r   <= vup_nxt;
    vdn_r   <= vdn_nxt;
    pnx_r   <= pnx_nxt;
  end

  assign price = price_r;
  assign value = value_r;

endmodule

// ===== sv/bermudan_put_binomial_pricer.sv =====
// items are priced one at a time; n = min(steps_in_use, MAX_STEPS)
// the n + 1 terminal prices enter the cell row one per cycle from the price generator,
// then each backward level runs a multiply state, then a combine state, in all cells at once
// reset (rst_n low, synchronous) loads config defaults and idles the control;
// node storage in the cells is not cleared
module bermudan_put_binomial_pricer #(
  parameter int MAX_STEPS = bbp_pkg::DEF_MAX_STEPS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bbp_pkg::VAL_W-1:0]        in_spot,
  input  logic [bbp_pkg::VAL_W-1:0]        in_strike,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bbp_pkg::VAL_W-1:0]        out_put_value
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1) + 1;

  // configuration
  logic [bbp_pkg::WGT_W-1:0]   up_prob_disc_r;
  logic [bbp_pkg::WGT_W-1:0]   down_prob_disc_r;
  logic [bbp_pkg::WGT_W-1:0]   down_factor_r;
  logic [bbp_pkg::WGT_W-1:0]   up_squared_r;
  logic [bbp_pkg::WGT_W-1:0]   lowest_factor_r;
  logic [bbp_pkg::STEPS_W-1:0] steps_in_use_r;
  logic [bbp_pkg::MASK_W-1:0]  exercise_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_prob_disc_r   <= '0;
      down_prob_disc_r <= '0;
      down_factor_r    <= bbp_pkg::RST_FACTOR;
      up_squared_r     <= bbp_pkg::RST_FACTOR;
      lowest_factor_r  <= bbp_pkg::RST_FACTOR;
      steps_in_use_r   <= bbp_pkg::RST_STEPS;
      exercise_mask_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbp_pkg::REG_UP_PROB_DISC:   up_prob_disc_r   <= cfg_wdata[bbp_pkg::WGT_W-1:0];
        bbp_pkg::REG_DOWN_PROB_DISC: down_prob_disc_r <= cfg_wdata[bbp_pkg::WGT_W-1:0];
        bbp_pkg::REG_DOWN_FACTOR:    down_factor_r    <= cfg_wdata[bbp_pkg::WGT_W-1:0];
        bbp_pkg::REG_UP_SQUARED:     up_squared_r     <= cfg_wdata[bbp_pkg::WGT_W-1:0];
        bbp_pkg::REG_LOWEST_FACTOR:  lowest_factor_r  <= cfg_wdata[bbp_pkg::WGT_W-1:0];
        bbp_pkg::REG_STEPS_IN_USE:   steps_in_use_r   <= cfg_wdata[bbp_pkg::STEPS_W-1:0];
        bbp_pkg::REG_EXERCISE_MASK:  exercise_mask_r  <= cfg_wdata[bbp_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control
  bbp_pkg::state_t           state_r, state_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          lvl_r, lvl_nxt;
  logic [bbp_pkg::VAL_W-1:0] strike_r, strike_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [bbp_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]          n_cfg;
  logic [CNT_W-1:0]          step_idx;
  logic [bbp_pkg::MASK_W-1:0] mask_sh;
  logic                      in_fire;
  logic                      out_free;
  logic                      gen_step;
  bbp_pkg::cell_ctl_t        cell_ctl;
  bbp_pkg::wgt_t             wgt;
  logic [bbp_pkg::VAL_W-1:0] cell_price [MAX_STEPS+1];
  logic [bbp_pkg::VAL_W-1:0] cell_value [MAX_STEPS+1];

  always_comb begin
    if (int'(steps_in_use_r) > MAX_STEPS) begin
      n_cfg = CNT_W'(MAX_STEPS);
    end else begin
      n_cfg = CNT_W'(steps_in_use_r);
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign step_idx = lvl_r - CNT_W'(1);
  // shifting past bit 63 leaves zero, so far steps never exercise
  assign mask_sh  = exercise_mask_r >> step_idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bbp_pkg::S_BUILD;
      end
      bbp_pkg::S_BUILD: begin
        if (cnt_r == n_r) begin
          state_nxt = (n_r == '0) ? bbp_pkg::S_FIN : bbp_pkg::S_MUL;
        end
      end
      bbp_pkg::S_MUL: state_nxt = bbp_pkg::S_UPD;
      bbp_pkg::S_UPD: begin
        state_nxt = (lvl_r == CNT_W'(1)) ? bbp_pkg::S_FIN : bbp_pkg::S_MUL;
      end
      bbp_pkg::S_FIN: begin
        if (out_free) state_nxt = bbp_pkg::S_IDLE;
      end
      default: state_nxt = bbp_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready        = 1'b0;
    gen_step        = 1'b0;
    cell_ctl.op     = bbp_pkg::CELL_HOLD;
    cell_ctl.ex     = mask_sh[0];
    cell_ctl.strike = strike_r;
    unique case (state_r)
      bbp_pkg::S_IDLE: in_ready = 1'b1;
      bbp_pkg::S_BUILD: begin
        gen_step    = 1'b1;
        cell_ctl.op = bbp_pkg::CELL_SHIFT;
      end
      bbp_pkg::S_MUL: cell_ctl.op = bbp_pkg::CELL_MUL;
      bbp_pkg::S_UPD: cell_ctl.op = bbp_pkg::CELL_UPD;
      bbp_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // datapath registers of the controller
  always_comb begin
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    strike_nxt    = strike_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (in_fire) begin
      n_nxt      = n_cfg;
      cnt_nxt    = '0;
      strike_nxt = in_strike;
    end
    if (state_r == bbp_pkg::S_BUILD) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      lvl_nxt = n_r;
    end
    if (state_r == bbp_pkg::S_UPD) lvl_nxt = lvl_r - CNT_W'(1);
    if (state_r == bbp_pkg::S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cell_value[MAX_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    lvl_r       <= lvl_nxt;
    strike_r    <= strike_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_put_value = out_value_r;

  // terminal price generator feeding the top cell
  logic [bbp_pkg::VAL_W-1:0] gen_price;
  logic [bbp_pkg::VAL_W-1:0] gen_value;

  bbp_gen u_gen (
    .clk                 (clk),
    .load                (in_fire),
    .step_en             (gen_step),
    .spot                (in_spot),
    .strike              (strike_r),
    .lowest_price_factor (lowest_factor_r),
    .up_squared          (up_squared_r),
    .price               (gen_price),
    .value               (gen_value)
  );

  assign wgt.up_prob_disc   = up_prob_disc_r;
  assign wgt.down_prob_disc = down_prob_disc_r;
  assign wgt.down_factor    = down_factor_r;

  // row of cells: terminal nodes shift down from the top, backward levels move up one cell,
  // so the root always ends in the top cell
  for (genvar j = 0; j <= MAX_STEPS; j++) begin : g_cell
    logic [bbp_pkg::VAL_W-1:0] sh_price;
    logic [bbp_pkg::VAL_W-1:0] sh_value;
    logic [bbp_pkg::VAL_W-1:0] lo_val;

    if (j == MAX_STEPS) begin : g_top
      assign sh_price = gen_price;
      assign sh_value = gen_value;
    end else begin : g_mid
      assign sh_price = cell_price[j+1];
      assign sh_value = cell_value[j+1];
    end

    if (j == 0) begin : g_bot
      assign lo_val = '0;
    end else begin : g_up
      assign lo_val = cell_value[j-1];
    end

    bbp_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .wgt         (wgt),
      .shift_price (sh_price),
      .shift_value (sh_value),
      .lo_value    (lo_val),
      .price       (cell_price[j]),
      .value       (cell_value[j])
    );
  end

endmodule

// ===== verif/tb_bermudan_put_binomial_pricer.sv =====
module tb_bermudan_put_binomial_pricer;

  localparam int  MAX_N           = bbp_pkg::DEF_MAX_STEPS;
  localparam int  RAND_PHASES     = 25;
  localparam int  ITEMS_PER_PHASE = 68;
  localparam int  SETTLE_CYCLES   = 8;
  localparam int  DRAIN_CYCLES    = 3 * MAX_N + 3 + 16;
  localparam int  LIMIT_TIME      = 40_000_000;
  localparam real Q30             = 1073741824.0;

  localparam logic [bbp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [bbp_pkg::WGT_W-1:0]   up_pd;
    logic [bbp_pkg::WGT_W-1:0]   dn_pd;
    logic [bbp_pkg::WGT_W-1:0]   dn_fac;
    logic [bbp_pkg::WGT_W-1:0]   up_sq;
    logic [bbp_pkg::WGT_W-1:0]   lowest;
    logic [bbp_pkg::STEPS_W-1:0] steps;
    logic [bbp_pkg::MASK_W-1:0]  mask;
  } lattice_cfg_t;

  typedef struct packed {
    logic [2:0]                cfg_id;
    logic [bbp_pkg::VAL_W-1:0] spot;
    logic [bbp_pkg::VAL_W-1:0] strike;
    logic                      known;
    logic [bbp_pkg::VAL_W-1:0] want;
  } option_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bbp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bbp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [bbp_pkg::VAL_W-1:0]      in_spot;
  logic [bbp_pkg::VAL_W-1:0]      in_strike;
  logic                           out_valid;
  logic                           out_ready;
  logic [bbp_pkg::VAL_W-1:0]      out_put_value;

  // lattice settings as the block should hold them
  logic [bbp_pkg::WGT_W-1:0]   wt_up;
  logic [bbp_pkg::WGT_W-1:0]   wt_dn;
  logic [bbp_pkg::WGT_W-1:0]   f_down;
  logic [bbp_pkg::WGT_W-1:0]   f_up_sq;
  logic [bbp_pkg::WGT_W-1:0]   f_lowest;
  logic [bbp_pkg::STEPS_W-1:0] n_steps;
  logic [bbp_pkg::MASK_W-1:0]  ex_mask;

  logic [bbp_pkg::VAL_W-1:0] put_value_q[$];
  logic [bbp_pkg::VAL_W-1:0] put_value_due;
  int                        n_errors;
  int                        stall_left;
  logic                      idle_on;

  lattice_cfg_t dir_cfgs [7];
  option_row_t  dir_rows [20];

  bermudan_put_binomial_pricer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_spot      (in_spot),
    .in_strike    (in_strike),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_put_value(out_put_value)
  );

  always #10 clk = ~clk;

  // (a * f) >> 30 on the full product, clipped to 48 bits
  function automatic logic [bbp_pkg::VAL_W-1:0] scale_q30(
      input logic [bbp_pkg::VAL_W-1:0] a,
      input logic [bbp_pkg::WGT_W-1:0] f);
    logic [79:0] prod;
    prod = {32'b0, a} * {48'b0, f};
    if (|prod[79:78]) return '1;
    return prod[77:30];
  endfunction

  function automatic logic [bbp_pkg::VAL_W-1:0] put_gain(input logic [bbp_pkg::VAL_W-1:0] k,
                                                         input logic [bbp_pkg::VAL_W-1:0] p);
    return (k > p) ? k - p : '0;
  endfunction

  function automatic logic [bbp_pkg::VAL_W-1:0] bermudan_put_value(
      input logic [bbp_pkg::VAL_W-1:0] spot,
      input logic [bbp_pkg::VAL_W-1:0] strike);
    logic [bbp_pkg::VAL_W-1:0] px [0:MAX_N];
    logic [bbp_pkg::VAL_W-1:0] vl [0:MAX_N];
    logic [bbp_pkg::VAL_W:0]   acc;
    logic [bbp_pkg::VAL_W-1:0] held;
    logic                      early;
    int                        n;
    n = (int'(n_steps) > MAX_N) ? MAX_N : int'(n_steps);
    px[0] = scale_q30(spot, f_lowest);
    for (int i = 1; i <= n; i++) px[i] = scale_q30(px[i-1], f_up_sq);
    for (int i = 0; i <= n; i++) vl[i] = put_gain(strike, px[i]);
    for (int k = n; k > 0; k--) begin
      early = ex_mask[k-1];
      for (int i = 0; i < k; i++) begin
        acc  = {1'b0, scale_q30(vl[i+1], wt_up)} + {1'b0, scale_q30(vl[i], wt_dn)};
        held = acc[bbp_pkg::VAL_W] ? '1 : acc[bbp_pkg::VAL_W-1:0];
        px[i] = scale_q30(px[i+1], f_down);
        if (early && put_gain(strike, px[i]) > held) held = put_gain(strike, px[i]);
        vl[i] = held;
      end
    end
    return vl[0];
  endfunction

  function automatic logic [bbp_pkg::WGT_W-1:0] wild_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic lattice_cfg_t wild_cfg();
    lattice_cfg_t c;
    c.up_pd  = wild_word();
    c.dn_pd  = wild_word();
    c.dn_fac = wild_word();
    c.up_sq  = wild_word();
    c.lowest = wild_word();
    c.steps  = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 8)) : 7'($urandom_range(0, 127));
    case ($urandom_range(0, 2))
      0: c.mask = '0;
      1: c.mask = '1;
      default: c.mask = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  // plausible market lattice: d < 1, u = 1/d, weights near one half
  function automatic lattice_cfg_t market_cfg();
    lattice_cfg_t c;
    real          d;
    real          p;
    real          disc;
    int           n;
    d    = $urandom_range(900, 995) / 1000.0;
    p    = $urandom_range(350, 650) / 1000.0;
    disc = $urandom_range(990, 1000) / 1000.0;
    n    = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    c.dn_fac = 32'($rtoi(d * Q30));
    c.up_sq  = 32'($rtoi(Q30 / (d * d)));
    c.lowest = 32'($rtoi((d ** real'(n)) * Q30));
    c.up_pd  = 32'($rtoi(p * disc * Q30));
    c.dn_pd  = 32'($rtoi((1.0 - p) * disc * Q30));
    c.steps  = 7'(n);
    case ($urandom_range(0, 2))
      0: c.mask = '0;
      1: c.mask = '1;
      default: c.mask = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  task automatic random_option(output logic [bbp_pkg::VAL_W-1:0] spot,
                               output logic [bbp_pkg::VAL_W-1:0] strike);
    case ($urandom_range(0, 9))
      0: begin
        spot   = 48'({$urandom, $urandom});
        strike = 48'({$urandom, $urandom});
      end
      1: begin
        spot   = $urandom_range(0, 1) ? '0 : 48'({$urandom, $urandom});
        strike = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        spot   = (48'($urandom_range(1, 2000)) << 24) | 48'($urandom_range(0, 24'hFF_FFFF));
        strike = 48'((64'(spot) * $urandom_range(70, 130)) / 100);
      end
    endcase
  endtask

  task automatic write_reg(input logic [bbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bbp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bbp_pkg::REG_UP_PROB_DISC:   wt_up    = data[bbp_pkg::WGT_W-1:0];
      bbp_pkg::REG_DOWN_PROB_DISC: wt_dn    = data[bbp_pkg::WGT_W-1:0];
      bbp_pkg::REG_DOWN_FACTOR:    f_down   = data[bbp_pkg::WGT_W-1:0];
      bbp_pkg::REG_UP_SQUARED:     f_up_sq  = data[bbp_pkg::WGT_W-1:0];
      bbp_pkg::REG_LOWEST_FACTOR:  f_lowest = data[bbp_pkg::WGT_W-1:0];
      bbp_pkg::REG_STEPS_IN_USE:   n_steps  = data[bbp_pkg::STEPS_W-1:0];
      bbp_pkg::REG_EXERCISE_MASK:  ex_mask  = data[bbp_pkg::MASK_W-1:0];
      default: ;
    endcase
  endtask

  // only while idle; upper data bits carry junk that must be dropped
  task automatic load_lattice(input lattice_cfg_t c);
    in_valid <= 1'b0;
    do @(posedge clk); while (put_value_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg(bbp_pkg::REG_UP_PROB_DISC, {$urandom, c.up_pd});
    write_reg(bbp_pkg::REG_DOWN_PROB_DISC, {$urandom, c.dn_pd});
    write_reg(bbp_pkg::REG_DOWN_FACTOR, {$urandom, c.dn_fac});
    write_reg(bbp_pkg::REG_UP_SQUARED, {$urandom, c.up_sq});
    write_reg(bbp_pkg::REG_LOWEST_FACTOR, {$urandom, c.lowest});
    write_reg(bbp_pkg::REG_STEPS_IN_USE, {$urandom, 25'($urandom), c.steps});
    write_reg(bbp_pkg::REG_EXERCISE_MASK, c.mask);
    cfg_we <= 1'b0;
  endtask

  // valid stays up across back-to-back beats; only a gap lowers it
  task automatic send_option(input logic [bbp_pkg::VAL_W-1:0] spot,
                             input logic [bbp_pkg::VAL_W-1:0] strike,
                             input logic known, input logic [bbp_pkg::VAL_W-1:0] want);
    logic [bbp_pkg::VAL_W-1:0] due;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_spot   <= spot;
    in_strike <= strike;
    do @(posedge clk); while (!in_ready);
    due = known ? want : bermudan_put_value(spot, strike);
    put_value_q = {put_value_q, due};
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (put_value_q.size() == 0) begin
        $error("put_value beat with nothing pending: actual %h", out_put_value);
        n_errors++;
      end else begin
        put_value_due = put_value_q.pop_front();
        if (out_put_value !== put_value_due) begin
          $error("put_value mismatch: expected %h, actual %h", put_value_due, out_put_value);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("bermudan_put_binomial_pricer test failed");
    $finish;
  end

  initial begin
    lattice_cfg_t              c;
    logic [2:0]                cur;
    logic [bbp_pkg::VAL_W-1:0] sp;
    logic [bbp_pkg::VAL_W-1:0] st;

    clk        = 1'b0;
    n_errors   = 0;
    stall_left = 0;
    idle_on    = 1'b1;
    wt_up      = '0;
    wt_dn      = '0;
    f_down     = bbp_pkg::RST_FACTOR;
    f_up_sq    = bbp_pkg::RST_FACTOR;
    f_lowest   = bbp_pkg::RST_FACTOR;
    n_steps    = bbp_pkg::RST_STEPS;
    ex_mask    = '0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_spot   <= '0;
    in_strike <= '0;
    out_ready <= 1'b0;

    dir_cfgs = '{
      '{32'd0, 32'd0, bbp_pkg::RST_FACTOR, bbp_pkg::RST_FACTOR, bbp_pkg::RST_FACTOR,
        bbp_pkg::RST_STEPS, 64'd0},
      '{32'd0, 32'd0, bbp_pkg::RST_FACTOR, bbp_pkg::RST_FACTOR, bbp_pkg::RST_FACTOR,
        7'd0, 64'd0},
      '{32'd536334741, 32'd528482304, 32'd1052266987, 32'd1118015233, 32'd1052266987,
        7'd1, 64'hAAAA_AAAA_AAAA_AAAB},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        7'd127, 64'hFFFF_FFFF_FFFF_FFFF},
      '{32'h3C00_0000, 32'h0400_0000, 32'd0, 32'd0, 32'd0, 7'd3, 64'd0},
      '{32'd536334741, 32'd532676608, 32'd1052266987, 32'd1118015233, 32'h1190_0000,
        7'd64, 64'h8000_0000_0000_0020},
      '{32'd536334741, 32'd532676608, 32'd1052266987, 32'd1118015233, 32'h1190_0000,
        7'd65, 64'hFFFF_FFFF_FFFF_FFFF}
    };

    // zero weights after reset give a zero root; zero steps give the plain payoff
    dir_rows = '{
      '{3'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0},
      '{3'd0, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0},
      '{3'd1, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{3'd1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0},
      '{3'd1, 48'h0000_6400_0000, 48'h0001_2C00_0000, 1'b1, 48'h0000_C800_0000},
      '{3'd1, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 1'b1, 48'h0},
      '{3'd2, 48'h0000_6400_0000, 48'h0000_6400_0000, 1'b0, 48'h0},
      '{3'd2, 48'h0000_6400_0000, 48'h0000_7800_0000, 1'b0, 48'h0},
      '{3'd2, 48'h0000_6400_0000, 48'h0000_5000_0000, 1'b0, 48'h0},
      '{3'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0},
      '{3'd3, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0},
      '{3'd3, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0, 48'h0},
      '{3'd4, 48'hFFFF_FFFF_FFFF, 48'h0000_6400_0000, 1'b0, 48'h0},
      '{3'd4, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0},
      '{3'd4, 48'h1234_5678_9ABC, 48'h0000_0000_0000, 1'b0, 48'h0},
      '{3'd5, 48'h0000_6400_0000, 48'h0000_6400_0000, 1'b0, 48'h0},
      '{3'd5, 48'h0000_6400_0000, 48'h0000_9600_0000, 1'b0, 48'h0},
      '{3'd5, 48'h0000_6400_0000, 48'h0000_3200_0000, 1'b0, 48'h0},
      '{3'd6, 48'h0000_6400_0000, 48'h0000_6E00_0000, 1'b0, 48'h0},
      '{3'd6, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cur = 3'd0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg_id != cur) begin
        cur = dir_rows[r].cfg_id;
        load_lattice(dir_cfgs[cur]);
      end
      send_option(dir_rows[r].spot, dir_rows[r].strike, dir_rows[r].known, dir_rows[r].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      c = ($urandom_range(0, 9) < 7) ? market_cfg() : wild_cfg();
      // last phase runs with both sides always ready
      idle_on <= (ph != RAND_PHASES - 1) && ($urandom_range(0, 4) != 0);
      load_lattice(c);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (put_value_q.size() != 0);
        end
        random_option(sp, st);
        send_option(sp, st, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (put_value_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("bermudan_put_binomial_pricer test passed");
    end else begin
      $display("bermudan_put_binomial_pricer test failed");
    end
    $finish;
  end

endmodule

// ===== bermudan_put_binomial_pricer.f =====
sv/bbp_pkg.sv
sv/bbp_gen.sv
sv/bbp_cell.sv
sv/bermudan_put_binomial_pricer.sv
verif/tb_bermudan_put_binomial_pricer.sv
